// File: rtl/core/lrmp_pkg.sv
// Shared types, constants and helpers of the linear recurrence matrix power block.
package lrmp_pkg;

    localparam int ORDER = 3;

    localparam logic [29:0] PRIME     = 30'd1000000007;
    localparam logic [31:0] PRIME_X2  = 32'd2000000014;
    // Barrett factor floor(2^60 / PRIME)
    localparam logic [63:0] MU_WIDE   = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] MU        = 31'(MU_WIDE);

    typedef enum logic [2:0] {
        REG_COEF_FIRST  = 3'd0,
        REG_COEF_SECOND = 3'd1,
        REG_COEF_THIRD  = 3'd2,
        REG_SEED_THREE  = 3'd3,
        REG_SEED_TWO    = 3'd4,
        REG_SEED_ONE    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,   // acc = acc * base
        OP_SQR = 2'd1,   // base = base * base
        OP_DOT = 2'd2    // bottom row of acc dotted with seeds
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_MUL,
        ST_MUL_DRAIN,
        ST_SQR,
        ST_SQR_DRAIN,
        ST_DOT_WAIT,
        ST_DOT,
        ST_DOT_DRAIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       init_wr;
        logic [3:0] idx;
        logic       issue;
        op_t        op;
        logic [1:0] ri;
        logic [1:0] rk;
        logic [1:0] rj;
        logic       last;
        logic       flip_acc;
        logic       flip_base;
        logic       shift;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic ex_zero;
        logic ex_lsb;
        logic out_full;
    } status_t;

    typedef struct packed {
        logic       valid;
        op_t        op;
        logic       last;
        logic [1:0] j;
        logic [3:0] dst;
    } tag_t;

    function automatic logic [3:0] entry_idx(input logic [1:0] r, input logic [1:0] c);
        return 4'({2'b00, r} * 4'(ORDER)) + {2'b00, c};
    endfunction

    function automatic logic [29:0] reduce_reg(input logic [29:0] v);
        return (v >= PRIME) ? (v - PRIME) : v;
    endfunction

endpackage

// File: rtl/core/lrmp_ram.sv
// Generic RAM with one write port and two registered read ports.
module lrmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: rtl/core/lrmp_ctrl.sv
// Sequencer that steps square-and-multiply and issues one product per cycle while in a multiply, square or dot state.
module lrmp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output lrmp_pkg::cmd_t    cmd,
    input  lrmp_pkg::status_t status
);
    import lrmp_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic [3:0] idx_reg, idx_next;
    logic       mat_end;

    assign mat_end = (i_reg == 2'd2) && (k_reg == 2'd2) && (j_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.op     = OP_MUL;
        cmd.ri     = i_reg;
        cmd.rk     = k_reg;
        cmd.rj     = j_reg;
        cmd.idx    = idx_reg;
        cmd.last   = (j_reg == 2'd2);

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    i_next     = '0;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (idx_reg == 4'd8) begin
                    state_next = ST_CHECK;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_CHECK: begin
                if (status.ex_zero) begin
                    state_next = ST_DOT_WAIT;
                end else if (status.ex_lsb) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SQR;
                end
            end
            ST_MUL, ST_SQR: begin
                cmd.issue = 1'b1;
                cmd.op    = (state_reg == ST_MUL) ? OP_MUL : OP_SQR;
                if (mat_end) begin
                    i_next     = '0;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = (state_reg == ST_MUL) ? ST_MUL_DRAIN : ST_SQR_DRAIN;
                end else if (j_reg == 2'd2) begin
                    j_next = '0;
                    if (k_reg == 2'd2) begin
                        k_next = '0;
                        i_next = i_reg + 2'd1;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else begin
                    j_next = j_reg + 2'd1;
                end
            end
            ST_MUL_DRAIN: begin
                if (!status.busy) begin
                    cmd.flip_acc = 1'b1;
                    state_next   = ST_SQR;
                end
            end
            ST_SQR_DRAIN: begin
                if (!status.busy) begin
                    cmd.flip_base = 1'b1;
                    cmd.shift     = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_DOT_WAIT: begin
                // hold until the previous result has left the output register
                if (!status.out_full) begin
                    i_next     = 2'd2;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                cmd.issue = 1'b1;
                cmd.op    = OP_DOT;
                if (j_reg == 2'd2) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_DOT_DRAIN;
                end else begin
                    j_next = j_reg + 2'd1;
                end
            end
            ST_DOT_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/lrmp_datapath.sv
// Matrix storage, config registers, pipelined modular multiplier and accumulator.
module lrmp_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [62:0]       term_index,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [29:0]       cfg_data,
    input  lrmp_pkg::cmd_t    cmd,
    output lrmp_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [29:0]       term_value
);
    import lrmp_pkg::*;

    // configuration registers
    logic [29:0] coef_first_reg, coef_second_reg, coef_third_reg;
    logic [29:0] seed_three_reg, seed_two_reg, seed_one_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_first_reg  <= 30'd1;
            coef_second_reg <= 30'd2;
            coef_third_reg  <= 30'd1;
            seed_three_reg  <= 30'd13;
            seed_two_reg    <= 30'd12;
            seed_one_reg    <= 30'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COEF_FIRST:  coef_first_reg  <= cfg_data;
                REG_COEF_SECOND: coef_second_reg <= cfg_data;
                REG_COEF_THIRD:  coef_third_reg  <= cfg_data;
                REG_SEED_THREE:  seed_three_reg  <= cfg_data;
                REG_SEED_TWO:    seed_two_reg    <= cfg_data;
                REG_SEED_ONE:    seed_one_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // exponent and bank pointers
    logic [62:0] ex_reg, ex_next;
    logic        acc_bank_reg, acc_bank_next, base_bank_reg, base_bank_next;

    always_comb begin
        ex_next        = ex_reg;
        acc_bank_next  = acc_bank_reg;
        base_bank_next = base_bank_reg;
        if (cmd.load) begin
            ex_next        = (term_index == '0) ? '0 : term_index - 63'd1;
            acc_bank_next  = 1'b0;
            base_bank_next = 1'b0;
        end else begin
            if (cmd.shift)     ex_next        = {1'b0, ex_reg[62:1]};
            if (cmd.flip_acc)  acc_bank_next  = ~acc_bank_reg;
            if (cmd.flip_base) base_bank_next = ~base_bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_reg        <= '0;
            acc_bank_reg  <= 1'b0;
            base_bank_reg <= 1'b0;
        end else begin
            ex_reg        <= ex_next;
            acc_bank_reg  <= acc_bank_next;
            base_bank_reg <= base_bank_next;
        end
    end

    // pipeline tags and data
    tag_t        tg1_reg, tg2_reg, tg3_reg, tg4_reg, tg5_reg, tg6_reg, tg0;
    logic [59:0] p2_reg, x3_reg, x4_reg, qp4_reg;
    logic [61:0] t3_reg;
    logic [31:0] r5_reg;
    logic [29:0] m6_reg;
    logic [29:0] acc_sum_reg, acc_sum_next;
    logic        m_valid_reg, m_valid_next;
    logic [29:0] m_data_reg;

    // retire stage
    logic [30:0] sum_w;
    logic [29:0] sum_red;
    logic        retire;

    assign sum_w   = {1'b0, acc_sum_reg} + {1'b0, m6_reg};
    assign sum_red = (sum_w >= {1'b0, PRIME}) ? 30'(sum_w - {1'b0, PRIME}) : sum_w[29:0];
    assign retire  = tg6_reg.valid && tg6_reg.last;

    // matrix RAMs
    logic        acc_we, base_we;
    logic [4:0]  acc_wa, base_wa;
    logic [29:0] acc_wd, base_wd, acc_rd, base_rd_a, base_rd_b;
    logic [4:0]  acc_ra, base_ra_a, base_ra_b;
    logic [29:0] init_acc, init_base;

    always_comb begin
        init_acc = (cmd.idx == 4'd0 || cmd.idx == 4'd4 || cmd.idx == 4'd8) ? 30'd1 : 30'd0;
        case (cmd.idx)
            4'd0:    init_base = reduce_reg(coef_first_reg);
            4'd1:    init_base = reduce_reg(coef_second_reg);
            4'd2:    init_base = reduce_reg(coef_third_reg);
            4'd3:    init_base = 30'd1;
            4'd7:    init_base = 30'd1;
            default: init_base = 30'd0;
        endcase
    end

    assign acc_we  = cmd.init_wr || (retire && tg6_reg.op == OP_MUL);
    assign acc_wa  = cmd.init_wr ? {1'b0, cmd.idx} : {~acc_bank_reg, tg6_reg.dst};
    assign acc_wd  = cmd.init_wr ? init_acc : sum_red;
    assign base_we = cmd.init_wr || (retire && tg6_reg.op == OP_SQR);
    assign base_wa = cmd.init_wr ? {1'b0, cmd.idx} : {~base_bank_reg, tg6_reg.dst};
    assign base_wd = cmd.init_wr ? init_base : sum_red;

    assign acc_ra    = {acc_bank_reg, entry_idx(cmd.ri, cmd.rj)};
    assign base_ra_a = {base_bank_reg, entry_idx(cmd.ri, cmd.rj)};
    assign base_ra_b = {base_bank_reg, entry_idx(cmd.rj, cmd.rk)};

    lrmp_ram #(.WIDTH(30), .DEPTH(32)) u_acc_ram (
        .aclk      (aclk),
        .we        (acc_we),
        .wr_addr   (acc_wa),
        .wr_data   (acc_wd),
        .rd_addr_a (acc_ra),
        .rd_addr_b (acc_ra),
        .rd_data_a (acc_rd),
        .rd_data_b ()
    );

    lrmp_ram #(.WIDTH(30), .DEPTH(32)) u_base_ram (
        .aclk      (aclk),
        .we        (base_we),
        .wr_addr   (base_wa),
        .wr_data   (base_wd),
        .rd_addr_a (base_ra_a),
        .rd_addr_b (base_ra_b),
        .rd_data_a (base_rd_a),
        .rd_data_b (base_rd_b)
    );

    // operand select, aligned with registered RAM data
    logic [29:0] op_x, op_y;

    always_comb begin
        op_x = (tg1_reg.op == OP_SQR) ? base_rd_a : acc_rd;
        if (tg1_reg.op == OP_DOT) begin
            case (tg1_reg.j)
                2'd0:    op_y = reduce_reg(seed_three_reg);
                2'd1:    op_y = reduce_reg(seed_two_reg);
                default: op_y = reduce_reg(seed_one_reg);
            endcase
        end else begin
            op_y = base_rd_b;
        end
    end

    always_comb begin
        tg0       = '0;
        tg0.valid = cmd.issue;
        tg0.op    = cmd.op;
        tg0.last  = cmd.last;
        tg0.j     = cmd.rj;
        tg0.dst   = entry_idx(cmd.ri, cmd.rk);
    end

    // Barrett reduction: q underestimates x / PRIME by at most two
    logic [61:0] t_w;
    logic [60:0] qp_w;
    logic [31:0] r_w;

    assign t_w  = 62'(p2_reg[59:29]) * 62'(MU);
    assign qp_w = 61'(t3_reg[61:31]) * 61'(PRIME);
    assign r_w  = x4_reg[31:0] - qp4_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tg1_reg <= '0;
            tg2_reg <= '0;
            tg3_reg <= '0;
            tg4_reg <= '0;
            tg5_reg <= '0;
            tg6_reg <= '0;
        end else begin
            tg1_reg <= tg0;
            tg2_reg <= tg1_reg;
            tg3_reg <= tg2_reg;
            tg4_reg <= tg3_reg;
            tg5_reg <= tg4_reg;
            tg6_reg <= tg5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p2_reg  <= 60'(op_x) * 60'(op_y);
        t3_reg  <= t_w;
        x3_reg  <= p2_reg;
        qp4_reg <= qp_w[59:0];
        x4_reg  <= x3_reg;
        r5_reg  <= r_w;
        if (r5_reg >= PRIME_X2) begin
            m6_reg <= 30'(r5_reg - PRIME_X2);
        end else if (r5_reg >= {2'b00, PRIME}) begin
            m6_reg <= 30'(r5_reg - {2'b00, PRIME});
        end else begin
            m6_reg <= r5_reg[29:0];
        end
    end

    // accumulate three products per entry, drop the sum after its last one
    always_comb begin
        acc_sum_next = acc_sum_reg;
        if (tg6_reg.valid) begin
            acc_sum_next = tg6_reg.last ? 30'd0 : sum_red;
        end
        m_valid_next = m_valid_reg;
        if (retire && tg6_reg.op == OP_DOT) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_sum_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_sum_reg <= acc_sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && tg6_reg.op == OP_DOT) begin
            m_data_reg <= sum_red;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign term_value = m_data_reg;

    assign status.busy     = tg1_reg.valid || tg2_reg.valid || tg3_reg.valid ||
                             tg4_reg.valid || tg5_reg.valid || tg6_reg.valid;
    assign status.ex_zero  = (ex_reg == '0);
    assign status.ex_lsb   = ex_reg[0];
    assign status.out_full = m_valid_reg;

    a_dot_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && tg6_reg.op == OP_DOT) |-> !m_valid_reg)
        else $error("final sum retired while output register still full");

    a_init_no_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init_wr |-> !tg6_reg.valid)
        else $error("matrix init overlaps a retiring product");

    a_flip_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flip_acc || cmd.flip_base) |-> !status.busy)
        else $error("bank flip while products are still in flight");

endmodule

// File: rtl/core/linear_recurrence_matrix_power_mod.sv
// Top level of the third-order linear recurrence term generator modulo 1000000007.
//
// Give the index n (from one) on the slave stream and receive P(n) mod 1000000007 on the
// master stream. Index zero behaves as index one. The block raises the 3x3 companion
// matrix to the power n-1 by square-and-multiply, then dots the bottom row with the seeds.
// One item is worked on at a time: s_tready is high only while the block is idle, and it
// takes the next index while a finished result still waits in the output register.
// s_tready rises again in the cycle after m_tvalid rises. The run time is set by the
// single modular multiplier pipeline, which accepts one product per cycle: each 3x3
// matrix product issues 27 products and then drains the six-stage pipeline (operand
// read, multiply, Barrett estimate, quotient times modulus, subtract, correction).
// Registers are written on the cfg channel (cfg_ready is always high) and should change
// only while the block is idle; index 0..5 selects coef_first, coef_second, coef_third,
// seed_three, seed_two, seed_one, other indices are ignored. Values at or above the
// modulus are reduced before use.
module linear_recurrence_matrix_power_mod (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] term_index, [63] zero fill
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [29:0] term_value, [31:30] zero fill
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data
);
    import lrmp_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [29:0] term_value;

    // sequence the exponent bits and issue products
    lrmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // hold matrices and registers, multiply and reduce
    lrmp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .term_index (s_tdata[62:0]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .term_value (term_value)
    );

    assign m_tdata = {2'b00, term_value};

endmodule
